[hw/rtl/fwcr_pkg.sv]
// Field weakening regulator: shared constants and register index codes.
// No dependencies.
package fwcr_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam int CFG_W      = 15;
   localparam int CFG_WIDE_W = 16;
   localparam int INJ_W      = 16;
   localparam int CALC_W     = 18;
   localparam int CMUL_W     = 16;
   localparam int CROOT_W    = 15;

   localparam logic [REG_IDX_W-1:0] REG_ENABLE    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_GAIN      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_EXIT_STEP = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STEP_LIM  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_INJ_LIM   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_CUR_LIM   = 3'd6;

   localparam logic [CFG_WIDE_W-1:0] THRESHOLD_RST = 16'd20000;
   localparam logic [CFG_WIDE_W-1:0] GAIN_RST      = 16'd256;
   localparam logic [CFG_W-1:0]      EXIT_STEP_RST = 15'd5;
   localparam logic [CFG_W-1:0]      STEP_LIM_RST  = 15'd50;
   localparam logic [CFG_W-1:0]      INJ_LIM_RST   = 15'd10000;
   localparam logic [CFG_W-1:0]      CUR_LIM_RST   = 15'd20000;

endpackage

[hw/rtl/field_weakening_current_regulator.sv]
// Voltage-feedback field weakening regulator, top level with APB registers.
// The work runs through the serial multiplier (two squares, then gain times excess) and the serial root.
// One tick in flight; the next word is taken once the result sits in the output register.
// Synchronous active-high reset: registers to defaults, injection and flag to zero.
// Uses fwcr_pkg, fwcr_mul and fwcr_sqrt.
module field_weakening_current_regulator #(
   parameter int VOLT_WIDTH    = 16,
   parameter int CURRENT_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // voltage_d, voltage_q, q_current_ref, zero pad
   input  logic [((2*VOLT_WIDTH+CURRENT_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // d_current_ref, zero pad
   output logic [((CURRENT_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // weakening_active
   output logic rsp_tuser,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [fwcr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fwcr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fwcr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   import fwcr_pkg::*;

   localparam int VW        = VOLT_WIDTH;
   localparam int CW        = CURRENT_WIDTH;
   localparam int RSP_W     = ((CW+7)/8)*8;
   localparam int MW        = (VW > CFG_WIDE_W) ? VW : CFG_WIDE_W;
   localparam int AW        = (CW > CFG_WIDE_W) ? CW : CFG_WIDE_W;
   localparam int TW        = (CW > CALC_W) ? CW : CALC_W;
   localparam int FLOOR_MAG = (CW > INJ_W) ? 32768 : (1 << (CW-1));
   localparam logic signed [CALC_W-1:0] FLOOR_VAL = CALC_W'(-FLOOR_MAG);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQ1  = 3'd1;
   localparam logic [2:0] S_SQ2  = 3'd2;
   localparam logic [2:0] S_ROOT = 3'd3;
   localparam logic [2:0] S_GAIN = 3'd4;
   localparam logic [2:0] S_UPD  = 3'd5;

   logic [2:0] state_ff, state_in;

   logic                  enable_ff;
   logic [CFG_WIDE_W-1:0] thr_ff;
   logic [CFG_WIDE_W-1:0] gain_ff;
   logic [CFG_W-1:0]      exit_ff;
   logic [CFG_W-1:0]      step_ff;
   logic [CFG_W-1:0]      ilim_ff;
   logic [CFG_W-1:0]      clim_ff;

   logic signed [INJ_W-1:0] inj_ff, inj_in;
   logic                    act_ff, act_in;
   logic                    over_ff;
   logic [VW-1:0]           aq_ff;
   logic [2*MW-1:0]         sq1_ff;
   logic                    rsp_valid_ff;
   logic [CW-1:0]           rsp_data_ff;
   logic                    rsp_user_ff;

   logic                  csr_wr;
   logic [REG_IDX_W-1:0]  csr_idx;
   logic                  accept;
   logic [VW-1:0]         vd_raw, vq_raw;
   logic [CW-1:0]         iq_raw;
   logic [VW-1:0]         ad, aq;
   logic [CW-1:0]         aiq;
   logic [AW-1:0]         aiq_ext;
   logic                  in_circle;
   logic [CFG_W-1:0]      cd;
   logic [CMUL_W-1:0]     cs;

   logic                  mv_start, mv_busy;
   logic [MW-1:0]         mv_a, mv_b;
   logic [2*MW-1:0]       mv_prod;
   logic                  mc_busy;
   logic [2*CMUL_W-1:0]   mc_prod;
   logic                  root_start;
   logic [2*MW-1:0]       sumsq;
   logic                  sv_busy, sc_busy;
   logic [VW-1:0]         mag;
   logic [CROOT_W-1:0]    bound;
   logic                  roots_done;
   logic [MW-1:0]         mag_ext, thr_ext, excess;
   logic                  over;
   logic [2*MW-17:0]      dec_raw;
   logic [CFG_W-1:0]      dec;
   logic                  upd_go;
   logic signed [CALC_W-1:0] inj18, t, dec18, exit18, ilim18, bnd18;
   logic signed [TW-1:0]  t_wide;

   // input fields
   assign vd_raw = req_tdata[VW-1:0];
   assign vq_raw = req_tdata[2*VW-1:VW];
   assign iq_raw = req_tdata[2*VW+CW-1:2*VW];

   assign ad  = vd_raw[VW-1] ? (~vd_raw + 1'b1) : vd_raw;
   assign aq  = vq_raw[VW-1] ? (~vq_raw + 1'b1) : vq_raw;
   assign aiq = iq_raw[CW-1] ? (~iq_raw + 1'b1) : iq_raw;

   // clim^2 - iq^2 = (clim - |iq|) * (clim + |iq|), zero outside the circle
   assign aiq_ext   = AW'(aiq);
   assign in_circle = (aiq_ext < AW'(clim_ff));
   assign cd        = clim_ff - aiq_ext[CFG_W-1:0];
   assign cs        = {1'b0, clim_ff} + {1'b0, aiq_ext[CFG_W-1:0]};

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      case (state_ff)
         S_IDLE: begin
            mv_a = MW'(ad);
            mv_b = MW'(ad);
         end
         S_SQ1: begin
            mv_a = MW'(aq_ff);
            mv_b = MW'(aq_ff);
         end
         S_ROOT: begin
            mv_a = MW'(gain_ff);
            mv_b = excess;
         end
         default: begin
            mv_a = '0;
            mv_b = '0;
         end
      endcase
   end

   assign roots_done = !sv_busy && !sc_busy;
   assign mag_ext    = MW'(mag);
   assign thr_ext    = MW'(thr_ff);
   assign over       = (mag_ext > thr_ext);
   assign excess     = mag_ext - thr_ext;

   assign mv_start = (accept && enable_ff)
                  || (state_ff == S_SQ1 && !mv_busy)
                  || (state_ff == S_ROOT && roots_done && over);
   assign root_start = (state_ff == S_SQ2) && !mv_busy;
   assign sumsq      = sq1_ff + mv_prod;

   fwcr_mul #(.W(MW)) u_mul_v (
      .clock   (clock),
      .reset   (reset),
      .start   (mv_start),
      .a       (mv_a),
      .b       (mv_b),
      .busy    (mv_busy),
      .product (mv_prod)
   );

   fwcr_mul #(.W(CMUL_W)) u_mul_c (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && enable_ff),
      .a       (in_circle ? {1'b0, cd} : {CMUL_W{1'b0}}),
      .b       (cs),
      .busy    (mc_busy),
      .product (mc_prod)
   );

   fwcr_sqrt #(.W(VW)) u_sqrt_v (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sumsq[2*VW-1:0]),
      .busy     (sv_busy),
      .root     (mag)
   );

   fwcr_sqrt #(.W(CROOT_W)) u_sqrt_c (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start && !mc_busy),
      .radicand (mc_prod[2*CROOT_W-1:0]),
      .busy     (sc_busy),
      .root     (bound)
   );

   // decrease = gain * excess / 65536, capped at the step limit
   assign dec_raw = mv_prod[2*MW-1:16];
   assign dec     = (dec_raw > (2*MW-16)'(step_ff)) ? step_ff : dec_raw[CFG_W-1:0];

   assign inj18  = CALC_W'(inj_ff);
   assign dec18  = $signed({3'b000, dec});
   assign exit18 = $signed({3'b000, exit_ff});
   assign ilim18 = $signed({3'b000, ilim_ff});
   assign bnd18  = $signed({3'b000, bound});

   always_comb begin
      t      = '0;
      act_in = 1'b0;
      if (enable_ff) begin
         if (over_ff) begin
            t      = inj18 - dec18;
            act_in = 1'b1;
         end else begin
            t = inj18;
            if (inj18 < 0) begin
               t = inj18 + exit18;
               if (t > 0) begin
                  t = '0;
               end
            end
            act_in = (t < 0) ? act_ff : 1'b0;
         end
         if (t < -ilim18) begin
            t = -ilim18;
         end
         if (t < -bnd18) begin
            t = -bnd18;
         end
         if (t < FLOOR_VAL) begin
            t = FLOOR_VAL;
         end
      end
   end

   assign inj_in = t[INJ_W-1:0];
   assign t_wide = TW'(t);
   assign upd_go = (state_ff == S_UPD) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = enable_ff ? S_SQ1 : S_UPD;
            end
         end
         S_SQ1: begin
            if (!mv_busy) begin
               state_in = S_SQ2;
            end
         end
         S_SQ2: begin
            if (!mv_busy) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (roots_done) begin
               state_in = over ? S_GAIN : S_UPD;
            end
         end
         S_GAIN: begin
            if (!mv_busy) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (upd_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         inj_ff       <= '0;
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (upd_go) begin
            inj_ff       <= inj_in;
            act_ff       <= act_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         aq_ff <= aq;
      end
      if (state_ff == S_SQ1 && !mv_busy) begin
         sq1_ff <= mv_prod;
      end
      if (state_ff == S_ROOT && roots_done) begin
         over_ff <= over;
      end else if (accept) begin
         over_ff <= 1'b0;
      end
      if (upd_go) begin
         rsp_data_ff <= t_wide[CW-1:0];
         rsp_user_ff <= act_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_user_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         thr_ff    <= THRESHOLD_RST;
         gain_ff   <= GAIN_RST;
         exit_ff   <= EXIT_STEP_RST;
         step_ff   <= STEP_LIM_RST;
         ilim_ff   <= INJ_LIM_RST;
         clim_ff   <= CUR_LIM_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ENABLE:    enable_ff <= csr_pwdata[0];
            REG_THRESHOLD: thr_ff    <= csr_pwdata[CFG_WIDE_W-1:0];
            REG_GAIN:      gain_ff   <= csr_pwdata[CFG_WIDE_W-1:0];
            REG_EXIT_STEP: exit_ff   <= csr_pwdata[CFG_W-1:0];
            REG_STEP_LIM:  step_ff   <= csr_pwdata[CFG_W-1:0];
            REG_INJ_LIM:   ilim_ff   <= csr_pwdata[CFG_W-1:0];
            REG_CUR_LIM:   clim_ff   <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ENABLE:    csr_prdata = CSR_DATA_W'(enable_ff);
         REG_THRESHOLD: csr_prdata = CSR_DATA_W'(thr_ff);
         REG_GAIN:      csr_prdata = CSR_DATA_W'(gain_ff);
         REG_EXIT_STEP: csr_prdata = CSR_DATA_W'(exit_ff);
         REG_STEP_LIM:  csr_prdata = CSR_DATA_W'(step_ff);
         REG_INJ_LIM:   csr_prdata = CSR_DATA_W'(ilim_ff);
         REG_CUR_LIM:   csr_prdata = CSR_DATA_W'(clim_ff);
         default:       csr_prdata = '0;
      endcase
   end

endmodule

[hw/rtl/fwcr_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Standalone; used by the field weakening regulator top level.
module fwcr_mul #(
   parameter int W = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic           busy,
   output logic [2*W-1:0] product
);

   localparam int CNT_W = $clog2(W);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [W-1:0]     a_ff;
   logic [W-1:0]     hi_ff;
   logic [W-1:0]     lo_ff;
   logic [W:0]       sum;

   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : {(W+1){1'b0}});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(W-1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= a;
         hi_ff <= '0;
         lo_ff <= b;
      end else if (busy_ff) begin
         hi_ff <= sum[W:1];
         lo_ff <= {sum[0], lo_ff[W-1:1]};
      end
   end

   assign busy    = busy_ff;
   assign product = {hi_ff, lo_ff};

endmodule

[hw/rtl/fwcr_sqrt.sv]
// Digit-serial integer square root, one root bit per cycle.
// Standalone; used by the field weakening regulator top level.
module fwcr_sqrt #(
   parameter int W = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [2*W-1:0] radicand,
   output logic           busy,
   output logic [W-1:0]   root
);

   localparam int CNT_W = $clog2(W);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [2*W-1:0]   rad_ff;
   logic [W+1:0]     rem_ff;
   logic [W-1:0]     root_ff;
   logic [W+3:0]     rem_sh;
   logic [W+3:0]     trial;
   logic             ge;
   logic [W+3:0]     rem_next;

   assign rem_sh   = {rem_ff, rad_ff[2*W-1:2*W-2]};
   assign trial    = {2'b00, root_ff, 2'b01};
   assign ge       = (rem_sh >= trial);
   assign rem_next = ge ? (rem_sh - trial) : rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(W-1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[2*W-3:0], 2'b00};
         rem_ff  <= rem_next[W+1:0];
         root_ff <= {root_ff[W-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule
